>>> hdl/lmpe_pkg.sv
// Shared constants, codes and types of the LED matrix pulse encoder.
// No dependencies; every other file but lmpe_ram refers to it by scoped names.
`default_nettype none

package lmpe_pkg;

   // Matrix geometry and chain length
   localparam int MATRIX_COLUMNS = 16;
   localparam int MATRIX_ROWS    = 16;
   localparam int LED_COUNT      = 256;

   // Frame layout in bytes
   localparam int LEAD_BYTES    = 8;
   localparam int TAIL_BYTES    = 24;
   localparam int BYTES_PER_LED = 24;
   localparam int PIXEL_BYTES   = (LED_COUNT - 1) * BYTES_PER_LED;
   localparam int FRAME_BYTES   = LEAD_BYTES + PIXEL_BYTES + TAIL_BYTES;

   // Widths
   localparam int COLOR_W = 24;
   localparam int ADDR_W  = $clog2(LED_COUNT);
   localparam int RAW_W   = $clog2(MATRIX_COLUMNS * MATRIX_ROWS + 1);
   localparam int CMP_W   = (RAW_W > ADDR_W) ? RAW_W + 1 : ADDR_W + 1;
   localparam int POS_W   = $clog2(FRAME_BYTES);
   localparam int SUB_W   = $clog2(BYTES_PER_LED);

   // Pattern bytes
   localparam logic [7:0] PULSE_ONE  = 8'hF0;
   localparam logic [7:0] PULSE_ZERO = 8'hC0;
   localparam logic [7:0] PULSE_IDLE = 8'h00;

   localparam logic [7:0] BRIGHT_FULL = 8'd255;

   // Request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_DEAD   = 2'd2;
   localparam logic [1:0] STATUS_BEYOND = 2'd3;

   // Channel order on the wire
   localparam logic [1:0] CHAN_GREEN = 2'd0;
   localparam logic [1:0] CHAN_RED   = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   // Word held between issue stage and encode stage
   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] status;
      logic       hit;      // store entry written since last clear
      logic       pix;      // tick falls in the pixel part of the frame
      logic [1:0] chan;
      logic [2:0] bit_sel;  // bit of the scaled channel, MSB first
      logic       last;
   } issue_type;

endpackage

`default_nettype wire

>>> hdl/lmpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module lmpe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/lmpe_issue.sv
// Issue stage: pixel addressing, entry valid bits, frame counters, stage register.
// Uses lmpe_pkg; drives the pixel RAM ports.
`default_nettype none

module lmpe_issue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [7:0]                  req_col,
   input  wire logic [7:0]                  req_row,
   input  wire logic [lmpe_pkg::COLOR_W-1:0] req_color,
   input  wire logic                        adv,
   output      logic                        s1_valid,
   output      lmpe_pkg::issue_type         s1_word,
   output      logic                        ram_we,
   output      logic [lmpe_pkg::ADDR_W-1:0] ram_waddr,
   output      logic [lmpe_pkg::COLOR_W-1:0] ram_wdata,
   output      logic                        ram_re,
   output      logic [lmpe_pkg::ADDR_W-1:0] ram_raddr
);

   logic                          accept;
   logic                          s1_valid_ff, s1_valid_in;
   lmpe_pkg::issue_type           s1_word_ff, s1_word_in;
   logic [lmpe_pkg::LED_COUNT-1:0] valid_ff, valid_in;
   logic [lmpe_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [lmpe_pkg::ADDR_W-1:0]   led_ff, led_in;
   logic [lmpe_pkg::SUB_W-1:0]    sub_ff, sub_in;

   logic                          in_matrix;
   logic [7:0]                    col_m;
   logic [lmpe_pkg::RAW_W-1:0]    raw;
   logic [lmpe_pkg::CMP_W-1:0]    idx;
   logic [1:0]                    loc_status;
   logic [1:0]                    status;
   logic                          pix;
   logic                          frame_end;
   logic                          write_ok;

   assign req_ready = !s1_valid_ff || adv;
   assign accept    = req_valid && req_ready;

   // Zigzag mapping, then step over the dead first LED
   always_comb begin
      in_matrix = ({1'b0, req_col} < 9'(lmpe_pkg::MATRIX_COLUMNS)) &&
                  ({1'b0, req_row} < 9'(lmpe_pkg::MATRIX_ROWS));
      col_m = req_row[0] ? (8'(lmpe_pkg::MATRIX_COLUMNS - 1) - req_col) : req_col;
      raw   = lmpe_pkg::RAW_W'(req_row) * lmpe_pkg::RAW_W'(lmpe_pkg::MATRIX_COLUMNS)
              + lmpe_pkg::RAW_W'(col_m);
      idx   = lmpe_pkg::CMP_W'(raw) - lmpe_pkg::CMP_W'(1);
      if (!in_matrix) begin
         loc_status = lmpe_pkg::STATUS_OUTSIDE;
      end else if (raw == '0) begin
         loc_status = lmpe_pkg::STATUS_DEAD;
      end else begin
         loc_status = lmpe_pkg::STATUS_OK;
      end
      unique case (req_mode)
         lmpe_pkg::MODE_WRITE: begin
            status = loc_status;
            if (loc_status == lmpe_pkg::STATUS_OK &&
                idx >= lmpe_pkg::CMP_W'(lmpe_pkg::LED_COUNT - 1)) begin
               status = lmpe_pkg::STATUS_BEYOND;
            end
         end
         lmpe_pkg::MODE_READ: begin
            status = loc_status;
            if (loc_status == lmpe_pkg::STATUS_OK &&
                idx >= lmpe_pkg::CMP_W'(lmpe_pkg::LED_COUNT)) begin
               status = lmpe_pkg::STATUS_BEYOND;
            end
         end
         default: begin
            status = lmpe_pkg::STATUS_OK;
         end
      endcase
   end

   assign write_ok  = accept && req_mode == lmpe_pkg::MODE_WRITE &&
                      status == lmpe_pkg::STATUS_OK;
   assign ram_we    = write_ok;
   assign ram_waddr = idx[lmpe_pkg::ADDR_W-1:0];
   assign ram_wdata = req_color;
   assign ram_re    = accept && (req_mode == lmpe_pkg::MODE_READ ||
                                 req_mode == lmpe_pkg::MODE_TICK);
   assign ram_raddr = (req_mode == lmpe_pkg::MODE_TICK) ? led_ff
                                                       : idx[lmpe_pkg::ADDR_W-1:0];

   assign pix = (pos_ff >= lmpe_pkg::POS_W'(lmpe_pkg::LEAD_BYTES)) &&
                (pos_ff < lmpe_pkg::POS_W'(lmpe_pkg::LEAD_BYTES + lmpe_pkg::PIXEL_BYTES));
   assign frame_end = pos_ff == lmpe_pkg::POS_W'(lmpe_pkg::FRAME_BYTES - 1);

   // Frame counters: byte position, LED in the chain, byte within the LED
   always_comb begin
      pos_in = pos_ff;
      led_in = led_ff;
      sub_in = sub_ff;
      if (accept && req_mode == lmpe_pkg::MODE_TICK) begin
         if (frame_end) begin
            pos_in = '0;
            led_in = '0;
            sub_in = '0;
         end else begin
            pos_in = pos_ff + lmpe_pkg::POS_W'(1);
            if (pix) begin
               if (sub_ff == lmpe_pkg::SUB_W'(lmpe_pkg::BYTES_PER_LED - 1)) begin
                  sub_in = '0;
                  led_in = led_ff + lmpe_pkg::ADDR_W'(1);
               end else begin
                  sub_in = sub_ff + lmpe_pkg::SUB_W'(1);
               end
            end
         end
      end
   end

   // Clear drops every valid bit at once; an entry not valid reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (accept && req_mode == lmpe_pkg::MODE_CLEAR) begin
         valid_in = '0;
      end else if (write_ok) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_comb begin
      s1_word_in         = s1_word_ff;
      s1_valid_in        = s1_valid_ff;
      if (accept) begin
         s1_valid_in        = 1'b1;
         s1_word_in.mode    = req_mode;
         s1_word_in.status  = status;
         s1_word_in.hit     = valid_ff[ram_raddr] && status == lmpe_pkg::STATUS_OK;
         s1_word_in.pix     = pix;
         s1_word_in.chan    = sub_ff[lmpe_pkg::SUB_W-1:3];
         s1_word_in.bit_sel = 3'd7 - sub_ff[2:0];
         s1_word_in.last    = frame_end;
      end else if (adv) begin
         s1_valid_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= '0;
         pos_ff      <= '0;
         led_ff      <= '0;
         sub_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         valid_ff    <= valid_in;
         pos_ff      <= pos_in;
         led_ff      <= led_in;
         sub_ff      <= sub_in;
      end
      s1_word_ff <= s1_word_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_word  = s1_word_ff;

endmodule

`default_nettype wire

>>> hdl/lmpe_encode.sv
// Encode stage: channel select, brightness scaling, pulse pattern, result register.
// Uses lmpe_pkg; takes the issue word and the registered RAM read data.
`default_nettype none

module lmpe_encode (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         s1_valid,
   input  wire lmpe_pkg::issue_type          s1_word,
   input  wire logic [lmpe_pkg::COLOR_W-1:0] ram_rdata,
   input  wire logic [7:0]                   brightness,
   output      logic                         adv,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [1:0]                   rsp_status,
   output      logic [lmpe_pkg::COLOR_W-1:0] rsp_read_color,
   output      logic [7:0]                   rsp_pulse_byte,
   output      logic                         rsp_frame_last
);

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    status_ff;
   logic [lmpe_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic [7:0]                    pulse_ff, pulse_in;
   logic                          last_ff, last_in;
   logic [lmpe_pkg::COLOR_W-1:0]  pixel;
   logic [7:0]                    chan_byte;
   logic [15:0]                   prod;
   logic [16:0]                   quot_sum;
   logic [7:0]                    scaled;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign pixel = s1_word.hit ? ram_rdata : '0;

   always_comb begin
      case (s1_word.chan)
         lmpe_pkg::CHAN_GREEN: chan_byte = pixel[15:8];
         lmpe_pkg::CHAN_RED:   chan_byte = pixel[23:16];
         lmpe_pkg::CHAN_BLUE:  chan_byte = pixel[7:0];
         default:              chan_byte = 8'd0;
      endcase
   end

   // x/255 for 16-bit x is (x + (x >> 8) + 1) >> 8
   assign prod     = 16'(chan_byte) * 16'(brightness);
   assign quot_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
   assign scaled   = quot_sum[15:8];

   always_comb begin
      color_in = '0;
      pulse_in = lmpe_pkg::PULSE_IDLE;
      last_in  = 1'b0;
      unique case (s1_word.mode)
         lmpe_pkg::MODE_READ: begin
            color_in = pixel;
         end
         lmpe_pkg::MODE_TICK: begin
            if (s1_word.pix) begin
               pulse_in = scaled[s1_word.bit_sel] ? lmpe_pkg::PULSE_ONE
                                                  : lmpe_pkg::PULSE_ZERO;
            end
            last_in = s1_word.last;
         end
         default: begin
            color_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = adv ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv && s1_valid) begin
         status_ff <= s1_word.status;
         color_ff  <= color_in;
         pulse_ff  <= pulse_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_color = color_ff;
   assign rsp_pulse_byte = pulse_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

>>> hdl/led_matrix_pulse_encoder_core.sv
// Top level of the LED matrix pulse encoder: brightness register, pixel RAM,
// issue and encode stages. Depends on lmpe_pkg, lmpe_ram, lmpe_issue, lmpe_encode.
//
// One word in, one word out. Each accepted word (pixel write, pixel read,
// store clear or stream tick) is registered in the issue stage and then in the
// encode stage; a new word is taken every cycle while the result side keeps
// up. The issue stage addresses the single pixel RAM, whose registered read
// the encode stage consumes. Clear drops every entry's valid bit at once, so
// there is no clearing pass after reset. Ticks walk the frame: lead-in zeros,
// G/R/B pattern bytes per LED, trailing zeros, rsp_frame_last on the final
// byte. Brightness must only be written while idle, unchecked by the block.
`default_nettype none

module led_matrix_pulse_encoder_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [7:0]                   csr_write_data,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [7:0]                   req_col,
   input  wire logic [7:0]                   req_row,
   input  wire logic [lmpe_pkg::COLOR_W-1:0] req_color,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [1:0]                   rsp_status,
   output      logic [lmpe_pkg::COLOR_W-1:0] rsp_read_color,
   output      logic [7:0]                   rsp_pulse_byte,
   output      logic                         rsp_frame_last
);

   logic [7:0]                    bright_ff;
   logic                          adv;
   logic                          s1_valid;
   lmpe_pkg::issue_type           s1_word;
   logic                          ram_we;
   logic [lmpe_pkg::ADDR_W-1:0]   ram_waddr;
   logic [lmpe_pkg::COLOR_W-1:0]  ram_wdata;
   logic                          ram_re;
   logic [lmpe_pkg::ADDR_W-1:0]   ram_raddr;
   logic [lmpe_pkg::COLOR_W-1:0]  ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= lmpe_pkg::BRIGHT_FULL;
      end else if (csr_write_en) begin
         bright_ff <= csr_write_data;
      end
   end

   lmpe_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_col   (req_col),
      .req_row   (req_row),
      .req_color (req_color),
      .adv       (adv),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr)
   );

   lmpe_ram #(
      .WIDTH (lmpe_pkg::COLOR_W),
      .DEPTH (lmpe_pkg::LED_COUNT)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lmpe_encode u_encode (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_word        (s1_word),
      .ram_rdata      (ram_rdata),
      .brightness     (bright_ff),
      .adv            (adv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_color (rsp_read_color),
      .rsp_pulse_byte (rsp_pulse_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

>>> bench/led_matrix_pulse_encoder_core_tb.sv
// Self-checking bench for led_matrix_pulse_encoder_core: pixel writes, reads,
// clears and stream ticks against a predictor of the frame and pixel store.
// Depends on lmpe_pkg and the core; needs nothing else.
`default_nettype none

module led_matrix_pulse_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_WORDS = 275;
   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE      = 4;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [7:0]                   col;
      logic [7:0]                   row;
      logic [lmpe_pkg::COLOR_W-1:0] color;
   } request_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic [lmpe_pkg::COLOR_W-1:0] read_color;
      logic [7:0]                   pulse_byte;
      logic                         frame_last;
   } reply_type;

   // Keeps its own copy of the store, frame position and brightness, and the
   // replies still owed by the core, oldest first.
   class pulse_scoreboard;
      logic [lmpe_pkg::COLOR_W-1:0] pixel_copy [lmpe_pkg::LED_COUNT];
      int unsigned                  frame_pos;
      logic [7:0]                   brightness;
      reply_type                    owed_replies [$];
      int unsigned                  failures, words_in, replies_seen, frame_ends;

      function new();
         foreach (pixel_copy[i]) pixel_copy[i] = '0;
         frame_pos    = 0;
         brightness   = lmpe_pkg::BRIGHT_FULL;
         failures     = 0;
         words_in     = 0;
         replies_seen = 0;
         frame_ends   = 0;
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction

      // zigzag wiring, first LED dead
      function logic [1:0] locate(input int col, input int row, output int idx);
         int raw;
         idx = 0;
         if (col >= lmpe_pkg::MATRIX_COLUMNS || row >= lmpe_pkg::MATRIX_ROWS)
            return lmpe_pkg::STATUS_OUTSIDE;
         raw = row * lmpe_pkg::MATRIX_COLUMNS +
               ((row % 2 == 1) ? lmpe_pkg::MATRIX_COLUMNS - 1 - col : col);
         if (raw == 0) return lmpe_pkg::STATUS_DEAD;
         idx = raw - 1;
         return lmpe_pkg::STATUS_OK;
      endfunction

      function logic [7:0] pattern_byte(input int unsigned pos);
         int unsigned                  k, led, chan, bitn, level;
         logic [lmpe_pkg::COLOR_W-1:0] px;
         if (pos < lmpe_pkg::LEAD_BYTES ||
             pos >= lmpe_pkg::LEAD_BYTES + lmpe_pkg::PIXEL_BYTES)
            return lmpe_pkg::PULSE_IDLE;
         k    = pos - lmpe_pkg::LEAD_BYTES;
         led  = k / lmpe_pkg::BYTES_PER_LED;
         chan = (k % lmpe_pkg::BYTES_PER_LED) / 8;
         bitn = 7 - k % 8;
         px   = pixel_copy[led];
         case (chan)
            lmpe_pkg::CHAN_GREEN: level = px[15:8];
            lmpe_pkg::CHAN_RED:   level = px[23:16];
            default:              level = px[7:0];
         endcase
         level = (level * brightness) / lmpe_pkg::BRIGHT_FULL;
         return ((level >> bitn) & 1) ? lmpe_pkg::PULSE_ONE : lmpe_pkg::PULSE_ZERO;
      endfunction

      function void note_request(input request_type rq);
         reply_type r;
         int        idx;
         r = '0;
         words_in++;
         case (rq.mode)
            lmpe_pkg::MODE_WRITE: begin
               r.status = locate(rq.col, rq.row, idx);
               if (r.status == lmpe_pkg::STATUS_OK) begin
                  if (idx >= lmpe_pkg::LED_COUNT - 1) r.status = lmpe_pkg::STATUS_BEYOND;
                  else pixel_copy[idx] = rq.color;
               end
            end
            lmpe_pkg::MODE_READ: begin
               r.status = locate(rq.col, rq.row, idx);
               if (r.status == lmpe_pkg::STATUS_OK) begin
                  if (idx >= lmpe_pkg::LED_COUNT) r.status = lmpe_pkg::STATUS_BEYOND;
                  else r.read_color = pixel_copy[idx];
               end
            end
            lmpe_pkg::MODE_CLEAR: foreach (pixel_copy[i]) pixel_copy[i] = '0;
            default: begin
               if (frame_pos >= lmpe_pkg::FRAME_BYTES) frame_pos = 0;
               r.pulse_byte = pattern_byte(frame_pos);
               if (frame_pos == lmpe_pkg::FRAME_BYTES - 1) begin
                  r.frame_last = 1'b1;
                  frame_pos = 0;
               end else begin
                  frame_pos++;
               end
            end
         endcase
         owed_replies.push_back(r);
      endfunction

      function void check_reply(input reply_type got);
         reply_type want;
         replies_seen++;
         if (owed_replies.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%t: reply with nothing owed: status %0d colour %h byte %h last %0d",
                        $realtime, got.status, got.read_color, got.pulse_byte, got.frame_last);
            return;
         end
         want = owed_replies.pop_front();
         if (want.frame_last) frame_ends++;
         if (got.status !== want.status || got.read_color !== want.read_color ||
             got.pulse_byte !== want.pulse_byte || got.frame_last !== want.frame_last) begin
            failures++;
            if (failures <= 10)
               $display("%t: reply %0d: status %0d/%0d colour %h/%h byte %h/%h last %0d/%0d",
                        $realtime, replies_seen, want.status, got.status, want.read_color,
                        got.read_color, want.pulse_byte, got.pulse_byte, want.frame_last,
                        got.frame_last);
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_en;
   logic [7:0]                   csr_write_data;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_mode;
   logic [7:0]                   req_col;
   logic [7:0]                   req_row;
   logic [lmpe_pkg::COLOR_W-1:0] req_color;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic [lmpe_pkg::COLOR_W-1:0] rsp_read_color;
   logic [7:0]                   rsp_pulse_byte;
   logic                         rsp_frame_last;

   pulse_scoreboard board;
   bit              calm = 1'b0;
   int              stall_left = 0;
   int              quiet_cycles = 0;
   int              settings = 1;
   request_type     seen_req;
   reply_type       seen_reply;

   led_matrix_pulse_encoder_core DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_color (rsp_read_color),
      .rsp_pulse_byte (rsp_pulse_byte),
      .rsp_frame_last (rsp_frame_last)
   );

   always #5 clock = ~clock;

   // result side back-pressure: short stalls, none while calm
   always @(negedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(99) < 6) stall_left = $urandom_range(6, 1);
      rsp_ready = (stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_req.mode  = req_mode;
            seen_req.col   = req_col;
            seen_req.row   = req_row;
            seen_req.color = req_color;
            board.note_request(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            seen_reply.status     = rsp_status;
            seen_reply.read_color = rsp_read_color;
            seen_reply.pulse_byte = rsp_pulse_byte;
            seen_reply.frame_last = rsp_frame_last;
            board.check_reply(seen_reply);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(negedge clock);
      $display("timeout: no word moved for %0d cycles, %0d replies owed",
               STALL_LIMIT, board.outstanding());
      $display("led_matrix_pulse_encoder_core_tb failed");
      $finish;
   end

   function automatic request_type word(input logic [1:0] mode, input logic [7:0] col,
                                        input logic [7:0] row,
                                        input logic [lmpe_pkg::COLOR_W-1:0] color);
      request_type r;
      r.mode  = mode;
      r.col   = col;
      r.row   = row;
      r.color = color;
      return r;
   endfunction

   // mostly inside the matrix, edges favoured; near_start keeps to the rows
   // the stream reaches early
   function automatic logic [7:0] pick_coord(input int limit, input bit near_start);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return 8'($urandom_range(255));
      if (roll < 18) return 8'($urandom_range(limit + 15, limit));
      if (roll < 30) return 8'(roll[0] ? limit - 1 : 0);
      if (near_start) return 8'($urandom_range(1));
      return 8'($urandom_range(limit - 1));
   endfunction

   function automatic request_type random_word();
      request_type r;
      int unsigned roll;
      roll    = $urandom_range(99);
      r.col   = pick_coord(lmpe_pkg::MATRIX_COLUMNS, 1'b0);
      r.row   = pick_coord(lmpe_pkg::MATRIX_ROWS, 1'($urandom_range(1)));
      r.color = ($urandom_range(4) == 0) ? ($urandom_range(1) ? '1 : '0)
                                         : lmpe_pkg::COLOR_W'($urandom());
      if (roll < 30)      r.mode = lmpe_pkg::MODE_WRITE;
      else if (roll < 55) r.mode = lmpe_pkg::MODE_READ;
      else if (roll < 57) r.mode = lmpe_pkg::MODE_CLEAR;
      else                r.mode = lmpe_pkg::MODE_TICK;
      return r;
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input request_type r);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_mode  = r.mode;
      req_col   = r.col;
      req_row   = r.row;
      req_color = r.color;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_level(input logic [7:0] level);
      drain();
      csr_write_data = level;
      csr_write_en   = 1'b1;
      @(negedge clock);
      csr_write_en     = 1'b0;
      board.brightness = level;
      settings++;
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_mode       = lmpe_pkg::MODE_WRITE;
      req_col        = '0;
      req_row        = '0;
      req_color      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // geometry corners and rejections; a write beyond the store cannot be
      // formed with a full square matrix
      send_word(word(lmpe_pkg::MODE_READ, 0, 0, 0));
      send_word(word(lmpe_pkg::MODE_WRITE, 0, 0, 24'hFFFFFF));
      send_word(word(lmpe_pkg::MODE_WRITE, 8'(lmpe_pkg::MATRIX_COLUMNS), 0, 24'h0F0F0F));
      send_word(word(lmpe_pkg::MODE_WRITE, 0, 8'(lmpe_pkg::MATRIX_ROWS), 24'h0F0F0F));
      send_word(word(lmpe_pkg::MODE_WRITE, 255, 255, 24'hFFFFFF));
      send_word(word(lmpe_pkg::MODE_READ, 255, 0, 0));
      send_word(word(lmpe_pkg::MODE_WRITE, 1, 0, 24'hFFFFFF));
      send_word(word(lmpe_pkg::MODE_WRITE, 0, 1, 24'h123456));
      send_word(word(lmpe_pkg::MODE_WRITE, 8'(lmpe_pkg::MATRIX_COLUMNS - 1), 1, 24'h00FF00));
      send_word(word(lmpe_pkg::MODE_WRITE, 0, 8'(lmpe_pkg::MATRIX_ROWS - 1), 24'hA5A5A5));
      send_word(word(lmpe_pkg::MODE_WRITE, 8'(lmpe_pkg::MATRIX_COLUMNS - 1),
                     8'(lmpe_pkg::MATRIX_ROWS - 1), 24'h5A5A5A));
      send_word(word(lmpe_pkg::MODE_READ, 1, 0, 0));
      send_word(word(lmpe_pkg::MODE_READ, 0, 1, 0));
      send_word(word(lmpe_pkg::MODE_READ, 8'(lmpe_pkg::MATRIX_COLUMNS - 1), 1, 0));
      send_word(word(lmpe_pkg::MODE_READ, 0, 8'(lmpe_pkg::MATRIX_ROWS - 1), 0));
      send_word(word(lmpe_pkg::MODE_READ, 8'(lmpe_pkg::MATRIX_COLUMNS - 1),
                     8'(lmpe_pkg::MATRIX_ROWS - 1), 24'hFFFFFF));
      send_word(word(lmpe_pkg::MODE_CLEAR, 3, 3, 24'hFFFFFF));
      send_word(word(lmpe_pkg::MODE_READ, 1, 0, 0));
      send_word(word(lmpe_pkg::MODE_WRITE, 1, 0, 24'hFF00A5));
      repeat (6) send_word(word(lmpe_pkg::MODE_TICK, 255, 255, 24'hFFFFFF));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: set_level(8'd0);
            2: set_level(8'd1);
            3: set_level(8'd128);
            4: set_level(8'($urandom_range(253, 2)));
            5: set_level(8'd254);
            default: ;
         endcase
         calm = (phase == 3);
         repeat (PHASE_WORDS) send_word(random_word());
      end

      drain();
      repeat (8) @(posedge clock);
      $display("%0d words in, %0d replies checked, %0d frame ends, %0d brightness settings",
               board.words_in, board.replies_seen, board.frame_ends, settings);
      $display("%0d mismatching replies", board.failures);
      if (board.failures == 0)
         $display("led_matrix_pulse_encoder_core_tb passed");
      else
         $display("led_matrix_pulse_encoder_core_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
